[hdl/dual_node_first_fit_placer_assert.svh]
// Assertion macros shared by the placer checker
`ifndef DUAL_NODE_FIRST_FIT_PLACER_ASSERT_SVH
`define DUAL_NODE_FIRST_FIT_PLACER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define DNP_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define DNP_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

[hdl/dnffp_pkg.sv]
// Shared types and constants of the dual-node first-fit placer
`default_nettype none
package dnffp_pkg;
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DEL = 1'b1;

    localparam logic [1:0] NODE_A    = 2'd0;
    localparam logic [1:0] NODE_B    = 2'd1;
    localparam logic [1:0] NODE_BOTH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;
    localparam logic [1:0] ST_BAD_HNDL = 2'd3;

    localparam int FREE_W = 10;
    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OPEN,
        S_PLACE,
        S_GIVE_BACK,
        S_RESULT
    } dnffp_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic rec_read;
        logic scan_clear;
        logic scan_read;
        logic scan_next;
        logic select;
        logic open_srv;
        logic take;
        logic give;
        logic load_result;
        logic [1:0] status;
    } dnffp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_del;
        logic h_range_bad;
        logic h_valid;
        logic scan_done;
        logic fit;
        logic too_big;
        logic full;
    } dnffp_stat_t;
endpackage
`default_nettype wire

[hdl/dual_node_first_fit_placer.sv]
// Top level of the dual-node first-fit placer
// Flow: accept, record lookup, decide; a bad handle goes straight to the result, a delete
// first gives its share back, and an add scans the open servers first-fit, placing on the
// first that fits, else opening a new one unless the request is too big or no slot is left.
// Throughput: one item at a time, held back further while the result is stalled.
// Reset: synchronous active-low aresetn clears state, open count and capacities (1024), then
// clears every placement record before the first beat is taken.
`default_nettype none
module dual_node_first_fit_placer
    import dnffp_pkg::*;
#(
    parameter int MAX_SERVERS = 256,
    parameter int MAX_HANDLES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [9:0]  s_vm_handle,
    input  wire logic [10:0] s_vm_cpu,
    input  wire logic [10:0] s_vm_memory,
    input  wire logic        s_vm_dual_node,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_server_index,
    output logic [1:0]       m_node_used,
    output logic             m_opened_new,
    output logic [1:0]       m_status
);
    dnffp_cmd_t  cmd;
    dnffp_stat_t stat;

    dnffp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .stat(stat)
    );

    dnffp_datapath #(.MAX_SERVERS(MAX_SERVERS), .MAX_HANDLES(MAX_HANDLES)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_cmd(s_cmd), .s_vm_handle(s_vm_handle), .s_vm_cpu(s_vm_cpu),
        .s_vm_memory(s_vm_memory), .s_vm_dual_node(s_vm_dual_node),
        .m_server_index(m_server_index), .m_node_used(m_node_used),
        .m_opened_new(m_opened_new), .m_status(m_status),
        .cmd(cmd), .stat(stat)
    );
endmodule
`default_nettype wire

[hdl/dnffp_ctrl.sv]
// Controller state machine of the placer
`default_nettype none
module dnffp_ctrl
    import dnffp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output dnffp_cmd_t       cmd,
    input  wire dnffp_stat_t stat
);
    dnffp_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign s_ready = (state_reg == S_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (stat.clear_done) state_next = S_IDLE;
            S_IDLE:     if (s_valid) state_next = S_LOOKUP;
            S_LOOKUP:   state_next = S_DECIDE;
            S_DECIDE: begin
                if (stat.h_range_bad) state_next = S_RESULT;
                else if (stat.is_del) state_next = stat.h_valid ? S_GIVE_BACK : S_RESULT;
                else if (stat.h_valid) state_next = S_RESULT;
                else state_next = S_SCAN_RD;
            end
            S_SCAN_RD:  state_next = stat.scan_done ? S_OPEN : S_SCAN_CHK;
            S_SCAN_CHK: state_next = stat.fit ? S_PLACE : S_SCAN_RD;
            S_OPEN: begin
                if (stat.too_big || stat.full) state_next = S_RESULT;
                else state_next = S_PLACE;
            end
            S_PLACE:     state_next = S_RESULT;
            S_GIVE_BACK: state_next = S_RESULT;
            S_RESULT:    if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_CLEAR:  cmd.clear = 1'b1;
            S_IDLE:   cmd.capture = s_valid;
            S_LOOKUP: cmd.rec_read = 1'b1;
            S_DECIDE: begin
                cmd.scan_clear = 1'b1;
                if (stat.h_range_bad) cmd.status = ST_BAD_HNDL;
                else if (stat.is_del ^ stat.h_valid) cmd.status = ST_BAD_HNDL;
            end
            S_SCAN_RD:  cmd.scan_read = !stat.scan_done;
            S_SCAN_CHK: begin
                cmd.scan_next = !stat.fit;
                cmd.select    = stat.fit;
            end
            S_OPEN: begin
                if (stat.too_big) cmd.status = ST_TOO_BIG;
                else if (stat.full) cmd.status = ST_NO_SLOT;
                else cmd.open_srv = 1'b1;
            end
            S_PLACE:     cmd.take = 1'b1;
            S_GIVE_BACK: cmd.give = 1'b1;
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[hdl/dnffp_datapath.sv]
// Datapath of the placer: server tables, placement records, scan logic
`default_nettype none
module dnffp_datapath
    import dnffp_pkg::*;
#(
    parameter int MAX_SERVERS = 256,
    parameter int MAX_HANDLES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_cmd,
    input  wire logic [9:0]  s_vm_handle,
    input  wire logic [10:0] s_vm_cpu,
    input  wire logic [10:0] s_vm_memory,
    input  wire logic        s_vm_dual_node,
    output logic [7:0]       m_server_index,
    output logic [1:0]       m_node_used,
    output logic             m_opened_new,
    output logic [1:0]       m_status,
    input  wire dnffp_cmd_t  cmd,
    output dnffp_stat_t      stat
);
    localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int HW = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;

    // live marks the handle as in use; the whole table is cleared after reset
    typedef struct packed {
        logic              live;
        logic [SW-1:0]     srv;
        logic [1:0]        node;
        logic [FREE_W:0]   cpu;
        logic [FREE_W:0]   mem;
    } rec_t;

    // per-server free amounts: one word of four fields
    logic [4*FREE_W-1:0] srv_mem [MAX_SERVERS];
    rec_t                rec_mem [MAX_HANDLES];

    logic [10:0] cap_cpu_reg, cap_mem_reg;
    logic        cmd_reg, dual_reg;
    logic [9:0]  handle_reg;
    logic [FREE_W:0] dc_reg, dm_reg;
    logic [CW-1:0] open_reg;
    logic [CW-1:0] scan_reg;
    logic [HW-1:0] clr_reg;
    logic [4*FREE_W-1:0] srv_rd_reg;
    rec_t          rec_rd_reg;
    logic [SW-1:0] sel_srv_reg;
    logic [1:0]    sel_node_reg;
    logic          opened_reg;
    logic [4*FREE_W-1:0] sel_word_reg;

    logic [HW-1:0] hidx;
    logic          h_bad;
    assign hidx  = handle_reg[HW-1:0];
    assign h_bad = (32'(handle_reg) >= 32'(MAX_HANDLES));

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_cpu_reg <= 11'd1024;
            cap_mem_reg <= 11'd1024;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) cap_cpu_reg <= cfg_data;
            else cap_mem_reg <= cfg_data;
        end
    end

    // capture request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg    <= s_cmd;
            handle_reg <= s_vm_handle;
            dual_reg   <= s_vm_dual_node;
            dc_reg     <= s_vm_dual_node ? {1'b0, s_vm_cpu[10:1]} : s_vm_cpu;
            dm_reg     <= s_vm_dual_node ? {1'b0, s_vm_memory[10:1]} : s_vm_memory;
        end
    end

    // fit test on the registered server word
    logic [FREE_W-1:0] fca, fcb, fma, fmb;
    logic fit_a, fit_b, fit;
    assign {fca, fcb, fma, fmb} = srv_rd_reg;
    assign fit_a = ({1'b0, fca} >= dc_reg) && ({1'b0, fma} >= dm_reg);
    assign fit_b = ({1'b0, fcb} >= dc_reg) && ({1'b0, fmb} >= dm_reg);
    assign fit   = dual_reg ? (fit_a && fit_b) : (fit_a || fit_b);

    logic [FREE_W-1:0] cap_c, cap_m;
    assign cap_c = cap_cpu_reg[10:1];
    assign cap_m = cap_mem_reg[10:1];

    // give back with saturation
    function automatic logic [FREE_W-1:0] add_sat(logic [FREE_W-1:0] a, logic [FREE_W:0] b);
        logic [FREE_W+1:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {2'b00, FREE_MAX}) ? FREE_MAX : s[FREE_W-1:0];
    endfunction

    logic [FREE_W-1:0] sca, scb, sma, smb;
    assign {sca, scb, sma, smb} = sel_word_reg;

    logic [4*FREE_W-1:0] take_word, give_word;
    always_comb begin
        logic [FREE_W-1:0] ta, tb, ua, ub;
        ta = sca; tb = scb; ua = sma; ub = smb;
        if (sel_node_reg != NODE_B) begin
            ta = sca - dc_reg[FREE_W-1:0];
            ua = sma - dm_reg[FREE_W-1:0];
        end
        if (sel_node_reg != NODE_A) begin
            tb = scb - dc_reg[FREE_W-1:0];
            ub = smb - dm_reg[FREE_W-1:0];
        end
        take_word = {ta, tb, ua, ub};
    end
    always_comb begin
        logic [FREE_W-1:0] ta, tb, ua, ub;
        ta = fca; tb = fcb; ua = fma; ub = fmb;
        if (rec_rd_reg.node != NODE_B) begin
            ta = add_sat(fca, rec_rd_reg.cpu);
            ua = add_sat(fma, rec_rd_reg.mem);
        end
        if (rec_rd_reg.node != NODE_A) begin
            tb = add_sat(fcb, rec_rd_reg.cpu);
            ub = add_sat(fmb, rec_rd_reg.mem);
        end
        give_word = {ta, tb, ua, ub};
    end

    // server table: one write port, one registered read port
    logic [SW-1:0] srv_raddr;
    always_comb begin
        if (cmd.scan_clear) srv_raddr = rec_rd_reg.srv;
        else srv_raddr = scan_reg[SW-1:0];
    end
    always_ff @(posedge aclk) begin
        if (cmd.take) srv_mem[sel_srv_reg] <= take_word;
        else if (cmd.give) srv_mem[rec_rd_reg.srv] <= give_word;
    end
    always_ff @(posedge aclk) begin
        if (cmd.scan_read || cmd.scan_clear) srv_rd_reg <= srv_mem[srv_raddr];
    end

    // clearing pass over the record table after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // record table: clear, place or release one entry
    always_ff @(posedge aclk) begin
        if (cmd.clear) rec_mem[clr_reg] <= '0;
        else if (cmd.take) rec_mem[hidx] <= '{1'b1, sel_srv_reg, sel_node_reg, dc_reg, dm_reg};
        else if (cmd.give) rec_mem[hidx] <= '0;
    end
    always_ff @(posedge aclk) begin
        if (cmd.rec_read) rec_rd_reg <= rec_mem[hidx];
    end

    // open count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (cmd.open_srv) begin
            open_reg <= open_reg + 1'b1;
        end
    end

    // scan pointer and selection
    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            scan_reg   <= '0;
            opened_reg <= 1'b0;
        end else if (cmd.scan_next) begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.rec_read) sel_node_reg <= NODE_A;
        if (cmd.select) begin
            sel_srv_reg  <= scan_reg[SW-1:0];
            sel_word_reg <= srv_rd_reg;
            sel_node_reg <= dual_reg ? NODE_BOTH : (fit_a ? NODE_A : NODE_B);
        end
        if (cmd.open_srv) begin
            sel_srv_reg  <= open_reg[SW-1:0];
            sel_word_reg <= {cap_c, cap_c, cap_m, cap_m};
            sel_node_reg <= dual_reg ? NODE_BOTH : NODE_A;
            opened_reg   <= 1'b1;
        end
    end

    // sticky error status
    logic [1:0] status_reg;
    always_ff @(posedge aclk) begin
        if (cmd.capture) status_reg <= ST_OK;
        else if (cmd.status != ST_OK) status_reg <= cmd.status;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_status <= ST_OK;
        end else if (cmd.load_result) begin
            m_status <= status_reg;
            if (status_reg != ST_OK) begin
                m_server_index <= '0;
                m_node_used    <= NODE_A;
                m_opened_new   <= 1'b0;
            end else if (cmd_reg == CMD_DEL) begin
                m_server_index <= 8'(rec_rd_reg.srv);
                m_node_used    <= rec_rd_reg.node;
                m_opened_new   <= 1'b0;
            end else begin
                m_server_index <= 8'(sel_srv_reg);
                m_node_used    <= sel_node_reg;
                m_opened_new   <= opened_reg;
            end
        end
    end

    assign stat.clear_done  = (32'(clr_reg) == 32'(MAX_HANDLES - 1));
    assign stat.is_del      = (cmd_reg == CMD_DEL);
    assign stat.h_range_bad = h_bad;
    assign stat.h_valid     = rec_rd_reg.live;
    assign stat.scan_done   = (scan_reg >= open_reg);
    assign stat.fit         = fit;
    assign stat.too_big     = (dc_reg > {1'b0, cap_c}) || (dm_reg > {1'b0, cap_m});
    assign stat.full        = (32'(open_reg) >= 32'(MAX_SERVERS));
endmodule
`default_nettype wire

[hdl/dnffp_checker.sv]
// Port-level checker of the placer and its bind
`default_nettype none
`include "dual_node_first_fit_placer_assert.svh"
module dnffp_checker
    import dnffp_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_node_used,
    input wire logic       m_opened_new,
    input wire logic [1:0] m_status
);
    `DNP_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted beat must block further input")
    `DNP_ASSERT_IMPL(a_node_code, aclk, aresetn, m_valid, m_node_used != 2'd3, "illegal node code")
    `DNP_ASSERT_IMPL(a_err_clean, aclk, aresetn, m_valid && m_status != ST_OK, !m_opened_new && m_node_used == NODE_A, "error result carries placement")
    `DNP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status), "result beat dropped or changed")
endmodule

bind dual_node_first_fit_placer dnffp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_node_used(m_node_used),
    .m_opened_new(m_opened_new), .m_status(m_status)
);
`default_nettype wire

[tb/sv/dual_node_first_fit_placer_checker.sv]
// Checker for the dual-node first-fit placer: watches both channels, predicts and compares
`default_nettype none
module dual_node_first_fit_placer_checker
    import dnffp_pkg::*;
#(
    parameter int MAX_SERVERS = 256,
    parameter int MAX_HANDLES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_cmd,
    input  wire logic [9:0]  s_vm_handle,
    input  wire logic [10:0] s_vm_cpu,
    input  wire logic [10:0] s_vm_memory,
    input  wire logic        s_vm_dual_node,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_server_index,
    input  wire logic [1:0]  m_node_used,
    input  wire logic        m_opened_new,
    input  wire logic [1:0]  m_status,
    output int               placements_due,
    output int               mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] server_index;
        logic [1:0] node_used;
        logic       opened_new;
        logic [1:0] status;
    } placement_result_t;

    placement_result_t results_due[$];

    // predictor state
    int         cpu_total, mem_total, open_count;
    int         cpu_free_a[MAX_SERVERS], cpu_free_b[MAX_SERVERS];
    int         mem_free_a[MAX_SERVERS], mem_free_b[MAX_SERVERS];
    bit         handle_live[MAX_HANDLES];
    int         rec_server[MAX_HANDLES], rec_cpu[MAX_HANDLES], rec_mem[MAX_HANDLES];
    logic [1:0] rec_node[MAX_HANDLES];

    function automatic int refill(int have, int amount);
        return (have + amount > FREE_MAX) ? int'(FREE_MAX) : have + amount;
    endfunction

    // place or release one request and return the result it should produce
    function automatic placement_result_t place_or_release(logic cmd, logic [9:0] h,
            logic [10:0] cpu, logic [10:0] mem, logic dual);
        placement_result_t res;
        int dc, dm, cap_c, cap_m, srv;
        bit found, fit_a, fit_b;
        logic [1:0] node;
        res = '0;
        found = 0;
        srv = 0;
        node = NODE_A;
        if (cmd == CMD_DEL) begin
            if (!handle_live[h]) begin
                res.status = ST_BAD_HNDL;
            end else begin
                srv = rec_server[h];
                node = rec_node[h];
                if (node != NODE_B) begin
                    cpu_free_a[srv] = refill(cpu_free_a[srv], rec_cpu[h]);
                    mem_free_a[srv] = refill(mem_free_a[srv], rec_mem[h]);
                end
                if (node != NODE_A) begin
                    cpu_free_b[srv] = refill(cpu_free_b[srv], rec_cpu[h]);
                    mem_free_b[srv] = refill(mem_free_b[srv], rec_mem[h]);
                end
                handle_live[h] = 0;
                res.server_index = srv[7:0];
                res.node_used = node;
            end
        end else if (handle_live[h]) begin
            res.status = ST_BAD_HNDL;
        end else begin
            dc = dual ? int'(cpu >> 1) : int'(cpu);
            dm = dual ? int'(mem >> 1) : int'(mem);
            // first fit over the open servers
            for (int i = 0; i < open_count && !found; i++) begin
                fit_a = cpu_free_a[i] >= dc && mem_free_a[i] >= dm;
                fit_b = cpu_free_b[i] >= dc && mem_free_b[i] >= dm;
                if (dual) begin
                    if (fit_a && fit_b) begin
                        node = NODE_BOTH;
                        found = 1;
                    end
                end else if (fit_a) begin
                    node = NODE_A;
                    found = 1;
                end else if (fit_b) begin
                    node = NODE_B;
                    found = 1;
                end
                if (found) srv = i;
            end
            if (!found) begin
                cap_c = cpu_total >> 1;
                cap_m = mem_total >> 1;
                if (dc > cap_c || dm > cap_m) begin
                    res.status = ST_TOO_BIG;
                end else if (open_count >= MAX_SERVERS) begin
                    res.status = ST_NO_SLOT;
                end else begin
                    srv = open_count;
                    open_count++;
                    cpu_free_a[srv] = cap_c;
                    cpu_free_b[srv] = cap_c;
                    mem_free_a[srv] = cap_m;
                    mem_free_b[srv] = cap_m;
                    node = dual ? NODE_BOTH : NODE_A;
                    res.opened_new = 1'b1;
                    found = 1;
                end
            end
            if (found) begin
                if (node != NODE_B) begin
                    cpu_free_a[srv] -= dc;
                    mem_free_a[srv] -= dm;
                end
                if (node != NODE_A) begin
                    cpu_free_b[srv] -= dc;
                    mem_free_b[srv] -= dm;
                end
                rec_server[h] = srv;
                rec_node[h] = node;
                rec_cpu[h] = dc;
                rec_mem[h] = dm;
                handle_live[h] = 1;
                res.server_index = srv[7:0];
                res.node_used = node;
            end
        end
        return res;
    endfunction

    // track configuration, predict accepted beats, compare returned beats
    always @(posedge aclk) begin
        placement_result_t want;
        if (!aresetn) begin
            cpu_total = 1024;
            mem_total = 1024;
            open_count = 0;
            foreach (handle_live[i]) handle_live[i] = 0;
            results_due.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index) mem_total = cfg_data;
                else cpu_total = cfg_data;
            end
            if (s_valid && s_ready)
                results_due.push_back(place_or_release(s_cmd, s_vm_handle, s_vm_cpu,
                                                       s_vm_memory, s_vm_dual_node));
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (m_server_index !== want.server_index) begin
                        $display("%0t: server_index expected %0d got %0d", $time,
                                 want.server_index, m_server_index);
                        mismatches++;
                    end
                    if (m_node_used !== want.node_used) begin
                        $display("%0t: node_used expected %0d got %0d", $time,
                                 want.node_used, m_node_used);
                        mismatches++;
                    end
                    if (m_opened_new !== want.opened_new) begin
                        $display("%0t: opened_new expected %0d got %0d", $time,
                                 want.opened_new, m_opened_new);
                        mismatches++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, m_status);
                        mismatches++;
                    end
                end
            end
        end
        placements_due = results_due.size();
    end

    initial mismatches = 0;
endmodule
`default_nettype wire

[tb/sv/dual_node_first_fit_placer_test.sv]
// Top of the placer testbench: clock, reset, stimulus and verdict
`default_nettype none
module dual_node_first_fit_placer_test
    import dnffp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REG_CPU_CORES = 1'b0;
    localparam logic REG_MEMORY    = 1'b1;

    logic        aclk = 0, aresetn = 0;
    logic        cfg_we = 0, cfg_index = REG_CPU_CORES;
    logic [10:0] cfg_data = '0;
    logic        s_valid = 0, s_ready;
    logic        s_cmd = CMD_ADD, s_vm_dual_node = 0;
    logic [9:0]  s_vm_handle = '0;
    logic [10:0] s_vm_cpu = '0, s_vm_memory = '0;
    logic        m_valid, m_ready = 0;
    logic [7:0]  m_server_index;
    logic [1:0]  m_node_used, m_status;
    logic        m_opened_new;
    int          placements_due, mismatches;

    bit          no_idle = 0;
    bit          handle_added[1024];
    int          cpu_total = 1024, mem_total = 1024;
    int          adds_sent = 0, deletes_sent = 0, settings_used = 1;

    dual_node_first_fit_placer uut (.*);
    dual_node_first_fit_placer_checker chk (.*);

    always #5 aclk = ~aclk;

    initial begin
        #30ms;
        $display("Timeout waiting for the placer");
        $display("Verification failed");
        $finish;
    end

    // result side: stall a random number of cycles per beat
    initial begin
        int stall;
        bit was_valid;
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready = 0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1;
            forever begin
                was_valid = m_valid;
                @(posedge aclk);
                if (was_valid) break;
                @(negedge aclk);
            end
        end
    end

    // drive one request beat, hold it until accepted, then drop valid
    task automatic send_request(logic cmd, logic [9:0] h, logic [10:0] cpu,
                                logic [10:0] mem, logic dual);
        int gap;
        bit was_ready;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1;
        s_cmd = cmd;
        s_vm_handle = h;
        s_vm_cpu = cpu;
        s_vm_memory = mem;
        s_vm_dual_node = dual;
        forever begin
            was_ready = s_ready;
            @(posedge aclk);
            if (was_ready) break;
            @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 0;
        if (cmd == CMD_ADD) begin
            adds_sent++;
            handle_added[h] = 1;
        end else begin
            deletes_sent++;
            handle_added[h] = 0;
        end
    endtask

    // let the block drain, then write both capacity registers
    task automatic set_capacity(int cpu, int mem);
        @(negedge aclk);
        s_valid = 0;
        wait (placements_due == 0);
        repeat (12) @(negedge aclk);
        cfg_we = 1;
        cfg_index = REG_CPU_CORES;
        cfg_data = cpu[10:0];
        @(negedge aclk);
        cfg_index = REG_MEMORY;
        cfg_data = mem[10:0];
        @(negedge aclk);
        cfg_we = 0;
        cpu_total = cpu;
        mem_total = mem;
        settings_used++;
    endtask

    function automatic logic [10:0] pick_demand(int total);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 11'($urandom_range(0, total / 3));
        if (r < 85) return 11'($urandom_range(0, total));
        return 11'($urandom_range(0, 1024));
    endfunction

    // random mix: mostly adds of fresh handles and deletes of added ones
    task automatic random_requests(int count, bit fill_slots);
        int r;
        logic [9:0] h;
        logic [10:0] cpu, mem;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            h = 10'($urandom_range(0, 1023));
            if (r < (fill_slots ? 15 : 35)) begin
                for (int k = 0; k < 40 && !handle_added[h]; k++)
                    h = 10'($urandom_range(0, 1023));
                send_request(CMD_DEL, h, 11'($urandom_range(0, 1024)),
                             11'($urandom_range(0, 1024)), 1'($urandom_range(0, 1)));
            end else if (r < (fill_slots ? 20 : 42)) begin
                // noise: arbitrary command and handle
                send_request(1'($urandom_range(0, 1)), h, 11'($urandom_range(0, 1024)),
                             11'($urandom_range(0, 1024)), 1'($urandom_range(0, 1)));
            end else begin
                for (int k = 0; k < 40 && handle_added[h]; k++)
                    h = 10'($urandom_range(0, 1023));
                if (fill_slots && r < 80) begin
                    send_request(CMD_ADD, h, 11'($urandom_range(2, 3)),
                                 11'($urandom_range(2, 3)), 1'b1);
                end else begin
                    cpu = pick_demand(cpu_total);
                    mem = pick_demand(mem_total);
                    send_request(CMD_ADD, h, cpu, mem, 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: extremes, reuse, errors, node A then B, dual with zero halves
        no_idle = 1;
        send_request(CMD_ADD, 10'd0, 11'd1024, 11'd1024, 1'b1);
        send_request(CMD_ADD, 10'd0, 11'd1, 11'd1, 1'b0);
        send_request(CMD_DEL, 10'd1023, 11'd0, 11'd0, 1'b0);
        send_request(CMD_ADD, 10'd1, 11'd1024, 11'd0, 1'b0);
        send_request(CMD_ADD, 10'd1, 11'd0, 11'd1024, 1'b0);
        send_request(CMD_ADD, 10'd1, 11'd0, 11'd0, 1'b0);
        no_idle = 0;
        send_request(CMD_ADD, 10'd2, 11'd1023, 11'd1023, 1'b1);
        send_request(CMD_ADD, 10'd3, 11'd1, 11'd1, 1'b0);
        send_request(CMD_ADD, 10'd4, 11'd1, 11'd1, 1'b0);
        send_request(CMD_ADD, 10'd5, 11'd512, 11'd512, 1'b0);
        send_request(CMD_ADD, 10'd6, 11'd512, 11'd512, 1'b0);
        send_request(CMD_ADD, 10'd1023, 11'd1, 11'd1, 1'b1);
        send_request(CMD_DEL, 10'd0, 11'd1024, 11'd1024, 1'b1);
        send_request(CMD_DEL, 10'd0, 11'd0, 11'd0, 1'b0);
        send_request(CMD_ADD, 10'd7, 11'd1024, 11'd1024, 1'b1);
        send_request(CMD_DEL, 10'd3, 11'd0, 11'd0, 1'b0);
        send_request(CMD_DEL, 10'd4, 11'd0, 11'd0, 1'b1);
        send_request(CMD_ADD, 10'd682, 11'd1, 11'd1, 1'b0);
        send_request(CMD_DEL, 10'd5, 11'd0, 11'd0, 1'b0);
        send_request(CMD_DEL, 10'd1023, 11'd0, 11'd0, 1'b0);

        random_requests(140, 0);
        set_capacity(2, 1024);
        random_requests(140, 0);
        set_capacity(1024, 2);
        random_requests(140, 0);
        set_capacity(700, 333);
        random_requests(150, 0);
        set_capacity(1024, 1024);
        random_requests(150, 0);
        set_capacity(2, 2);
        random_requests(410, 1);

        @(negedge aclk);
        s_valid = 0;
        wait (placements_due == 0);
        repeat (40) @(posedge aclk);
        $display("Placed %0d adds and %0d deletes under %0d capacity settings,",
                 adds_sent, deletes_sent, settings_used);
        $display("including filled server slots and bad-handle requests.");
        if (mismatches == 0 && placements_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hdl
hdl/dnffp_pkg.sv
hdl/dnffp_ctrl.sv
hdl/dnffp_datapath.sv
hdl/dual_node_first_fit_placer.sv
hdl/dnffp_checker.sv
tb/sv/dual_node_first_fit_placer_checker.sv
tb/sv/dual_node_first_fit_placer_test.sv
